[hdl/hfes_pkg.sv]
// Shared types and constants for the HID field extract and scale block.
// Used by hfes_ctrl, hfes_dpath and hid_field_extract_scale; depends on nothing.
package hfes_pkg;

   // Report length limit and the widths that follow from it.
   localparam int MAX_REPORT_BYTES = 64;
   localparam int CNT_W            = $clog2(MAX_REPORT_BYTES + 1);
   // The last byte index of a field is a 7-bit value (offset plus size, over 8).
   localparam int END_W            = 7;
   localparam int LEN_W            = (CNT_W > END_W) ? CNT_W : END_W;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BIT_OFFSET  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_SIZE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOGICAL_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOGICAL_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_MODE = 3'd4;

   // Output modes.
   localparam logic [1:0] MODE_RAW     = 2'd0;
   localparam logic [1:0] MODE_SIGNED  = 2'd1;
   localparam logic [1:0] MODE_SCALE_U = 2'd2;
   localparam logic [1:0] MODE_SCALE_S = 2'd3;

   // Register reset values.
   localparam logic [8:0]  OFFSET_RST = 9'd0;
   localparam logic [5:0]  SIZE_RST   = 6'd8;
   localparam logic [31:0] MIN_RST    = 32'd0;
   localparam logic [31:0] MAX_RST    = 32'd255;

   // Field and scaling constants.
   localparam logic [5:0] FIELD_MAX_BITS = 6'd32;
   localparam logic [7:0] ZERO_RANGE_U   = 8'd127;
   localparam logic [7:0] SIGN_FLIP      = 8'd128;

   // Restoring divider: one quotient bit per cycle, quotient fits 0..255.
   localparam int DIV_STEPS = 8;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_GATHER,
      ST_EXTRACT,
      ST_CLAMP,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } hfes_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_byte;
      logic capture;
      logic extract;
      logic clamp;
      logic load_div;
      logic div_step;
      logic load_out;
   } hfes_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scale_mode;
   } hfes_sts_type;

endpackage

[hdl/hfes_ctrl.sv]
// Controller state machine of the HID field extract and scale block.
// Depends on hfes_pkg; drives the datapath through hfes_cmd_type.
module hfes_ctrl
   import hfes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last_byte,
   input  logic         rsp_stall,
   input  hfes_sts_type sts,
   output logic         req_stall,
   output logic         rsp_valid,
   output hfes_cmd_type cmd
);

   hfes_state_type       state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // State, step counter and result valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_GATHER;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_GATHER: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take_byte = 1'b1;
               if (req_last_byte) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_EXTRACT;
               end
            end
         end
         ST_EXTRACT: begin
            cmd.extract = 1'b1;
            state_in    = sts.scale_mode ? ST_CLAMP : ST_DONE;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load_div = 1'b1;
            div_cnt_in   = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Wait until the output register is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = ST_GATHER;
            end
         end
         default: begin
            state_in = ST_GATHER;
         end
      endcase
   end

   // The result stays valid until it is taken.
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/hfes_dpath.sv]
// Datapath of the HID field extract and scale block: registers, byte gather,
// field extraction, clamp and a restoring divider. Depends on hfes_pkg.
module hfes_dpath
   import hfes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  hfes_cmd_type          cmd,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [7:0]            req_report_byte,
   output hfes_sts_type          sts,
   output logic signed [32:0]    rsp_field_value,
   output logic                  rsp_field_missing
);

   // Configuration registers.
   logic [8:0]  field_pos_ff;
   logic [5:0]  field_width_ff;
   logic [31:0] logical_min_ff;
   logic [31:0] logical_max_ff;
   logic [1:0]  output_mode_ff;

   // Gather state and the captured report.
   logic [CNT_W-1:0] count_ff;
   logic [31:0]      window_ff;
   logic [CNT_W-1:0] cap_len_ff;
   logic [31:0]      cap_window_ff;

   // Extract, clamp and divide stages.
   logic [31:0] raw_ff, ext_ff;
   logic        missing_ff;
   logic [31:0] dist_ff, range_ff;
   logic        rev_ff;
   logic [39:0] rem_ff;
   logic [38:0] dsr_ff;
   logic [7:0]  quo_ff;

   // Output register.
   logic [32:0] value_ff;
   logic        missing_out_ff;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         field_pos_ff   <= OFFSET_RST;
         field_width_ff <= SIZE_RST;
         logical_min_ff <= MIN_RST;
         logical_max_ff <= MAX_RST;
         output_mode_ff <= MODE_RAW;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BIT_OFFSET:  field_pos_ff   <= csr_wdata[8:0];
            CSR_BIT_SIZE:    field_width_ff <= csr_wdata[5:0];
            CSR_LOGICAL_MIN: logical_min_ff <= csr_wdata;
            CSR_LOGICAL_MAX: logical_max_ff <= csr_wdata;
            CSR_OUTPUT_MODE: output_mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign sts.scale_mode = output_mode_ff[1];

   // Byte gather: the four bytes from the field's start byte form the window.
   logic [LEN_W-1:0] count_ext, start_ext, rel;
   logic             in_window, not_full;
   logic [31:0]      window_in;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      count_ext = LEN_W'(count_ff);
      start_ext = LEN_W'(field_pos_ff[8:3]);
      rel       = count_ext - start_ext;
      in_window = (count_ext >= start_ext) && (rel < LEN_W'(4));
      not_full  = count_ff < CNT_W'(MAX_REPORT_BYTES);
      window_in = window_ff;
      count_in  = count_ff;
      if (not_full) begin
         count_in = count_ff + 1'b1;
         if (in_window) begin
            window_in = window_ff | (32'(req_report_byte) << {rel[1:0], 3'b000});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         window_ff <= '0;
      end else if (cmd.take_byte) begin
         if (cmd.capture) begin
            count_ff  <= '0;
            window_ff <= '0;
         end else begin
            count_ff  <= count_in;
            window_ff <= window_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_len_ff    <= count_in;
         cap_window_ff <= window_in;
      end
   end

   // Field extraction, missing check and sign extension to the field size.
   logic        size_ok, narrow, missing, top_set;
   logic [9:0]  end_bit;
   logic [32:0] mask33;
   logic [31:0] mask, raw, ext;
   logic [4:0]  sign_pos;

   always_comb begin
      size_ok  = (field_width_ff != 6'd0) && (field_width_ff <= FIELD_MAX_BITS);
      narrow   = (field_width_ff != 6'd0) && (field_width_ff < FIELD_MAX_BITS);
      end_bit  = 10'(field_pos_ff) + 10'(field_width_ff) - 10'd1;
      missing  = !size_ok || (LEN_W'(end_bit[9:3]) >= LEN_W'(cap_len_ff));
      mask33   = (33'd1 << field_width_ff) - 33'd1;
      mask     = mask33[31:0];
      raw      = missing ? 32'd0 : ((cap_window_ff >> field_pos_ff[2:0]) & mask);
      sign_pos = 5'(field_width_ff - 6'd1);
      top_set  = raw[sign_pos];
      ext      = (narrow && top_set) ? (raw | ~mask) : raw;
   end

   always_ff @(posedge clock) begin
      if (cmd.extract) begin
         raw_ff     <= raw;
         ext_ff     <= ext;
         missing_ff <= missing;
      end
   end

   // Clamp to the logical range and take the distance from its low end.
   logic               rev;
   logic signed [31:0] lo, hi, v, vc;
   logic [32:0]        dist33, range33;

   always_comb begin
      rev     = $signed(logical_min_ff) > $signed(logical_max_ff);
      lo      = rev ? $signed(logical_max_ff) : $signed(logical_min_ff);
      hi      = rev ? $signed(logical_min_ff) : $signed(logical_max_ff);
      v       = lo[31] ? $signed(ext_ff) : $signed(raw_ff);
      if (v < lo) begin
         vc = lo;
      end else if (v > hi) begin
         vc = hi;
      end else begin
         vc = v;
      end
      dist33  = {vc[31], vc} - {lo[31], lo};
      range33 = {hi[31], hi} - {lo[31], lo};
   end

   always_ff @(posedge clock) begin
      if (cmd.clamp) begin
         dist_ff  <= dist33[31:0];
         range_ff <= range33[31:0];
         rev_ff   <= rev;
      end
   end

   // Restoring divider; the numerator is distance times 255, plus half the
   // range for rounding in the signed scale mode.
   logic        signed_scale;
   logic [39:0] numer;
   logic [40:0] diff;
   logic        ge;

   always_comb begin
      signed_scale = output_mode_ff == MODE_SCALE_S;
      numer        = ({8'd0, dist_ff} << 8) - {8'd0, dist_ff}
                   + (signed_scale ? 40'(range_ff >> 1) : 40'd0);
      diff         = {1'b0, rem_ff} - {2'b00, dsr_ff};
      ge           = !diff[40];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_div) begin
         rem_ff <= numer;
         dsr_ff <= {range_ff, 7'd0};
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         if (ge) begin
            rem_ff <= diff[39:0];
         end
         dsr_ff <= dsr_ff >> 1;
         quo_ff <= {quo_ff[6:0], ge};
      end
   end

   // Result selection by output mode.
   logic [7:0]  code;
   logic [32:0] scaled, value;

   always_comb begin
      code = (rev_ff ? ~quo_ff : quo_ff) ^ (signed_scale ? SIGN_FLIP : 8'd0);
      if (range_ff == 32'd0) begin
         scaled = signed_scale ? 33'd0 : 33'(ZERO_RANGE_U);
      end else if (signed_scale) begin
         scaled = {{25{code[7]}}, code};
      end else begin
         scaled = {25'd0, code};
      end
      case (output_mode_ff)
         MODE_RAW:     value = {1'b0, raw_ff};
         MODE_SIGNED:  value = {ext_ff[31], ext_ff};
         MODE_SCALE_U: value = scaled;
         MODE_SCALE_S: value = scaled;
         default:      value = scaled;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         value_ff       <= value;
         missing_out_ff <= missing_ff;
      end
   end

   assign rsp_field_value   = $signed(value_ff);
   assign rsp_field_missing = missing_out_ff;

endmodule

[hdl/hid_field_extract_scale.sv]
// Top level of the HID field extract and scale block.
// Depends on hfes_pkg, hfes_ctrl and hfes_dpath.
//
// Report bytes are taken one per cycle, byte zero first, and the field is
// gathered on the fly. When the last byte of a report is taken, the input
// stalls while the result is worked out in the extract and done states and,
// in the scaling modes, also in the clamp, load and divide states, dividing by
// the logical range in a restoring divider at one quotient bit per cycle.
// The result then sits in an output register until it is taken; the next
// report may start arriving meanwhile; its result waits for the register to
// empty. Configuration must be written only while the block is idle (unchecked).
module hid_field_extract_scale
   import hfes_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_report_byte,
   input  logic                  req_last_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [32:0]    rsp_field_value,
   output logic                  rsp_field_missing,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   hfes_cmd_type cmd;
   hfes_sts_type sts;

   hfes_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .rsp_stall     (rsp_stall),
      .sts           (sts),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .cmd           (cmd)
   );

   hfes_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_report_byte   (req_report_byte),
      .sts               (sts),
      .rsp_field_value   (rsp_field_value),
      .rsp_field_missing (rsp_field_missing)
   );

   // Right after the last byte of a report is taken, no byte is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_byte) |=> req_stall)
      else $error("byte taken right after the last byte of a report");

   // A new result never overwrites one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_valid && rsp_stall))
      else $error("result register loaded while a result is pending");

   // A result appears only after the controller has loaded it.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_out))
      else $error("result valid without a load");

endmodule
